// File: rtl/i8dp_pkg.sv
`default_nettype none
package i8dp_pkg;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_SCALE,
    ST_EMIT
  } state_t;

  // item commands
  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_VECTOR = 1'b1;

  // configuration register indexes
  localparam logic CFG_SCALE  = 1'b0;
  localparam logic CFG_LENGTH = 1'b1;

  // field and datapath widths
  localparam int IDX_W   = 8;
  localparam int VAL_W   = 8;
  localparam int LEN_W   = 9;
  localparam int SCALE_W = 32;
  localparam int ACC_W   = 24;
  localparam int PROD_W  = ACC_W + SCALE_W;
  localparam int SCORE_W = 39;
  localparam int VNUM_W  = 16;
  localparam int QDEPTH  = 256;

  // effective length limit and reset values
  localparam logic [LEN_W-1:0]   MAX_LENGTH   = 9'd256;
  localparam logic [LEN_W-1:0]   LENGTH_RESET = 9'd256;
  localparam logic [SCALE_W-1:0] SCALE_RESET  = 32'h0001_0000;

  // score saturation limits
  localparam logic [SCORE_W-1:0] SCORE_MAX = {1'b0, {(SCORE_W-1){1'b1}}};
  localparam logic [SCORE_W-1:0] SCORE_MIN = {1'b1, {(SCORE_W-1){1'b0}}};

endpackage
`default_nettype wire

// File: rtl/int8_dot_product_scorer.sv
// Query load and out-of-range element: handled in idle, back in idle at once.
// Vector element below the length: accept, multiply, accumulate, then back to idle.
// Last element of a vector: accept, multiply, accumulate, scale, emit; score shows on out_valid
// after the emit step, later if the output register is still occupied.
// Every product goes through one shared 24x32 multiplier and its register.
// Synchronous reset: idle, sum and counter zero, scale 1.0, length 256, query memory kept.
`default_nettype none
module int8_dot_product_scorer (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // item channel
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic                                command,
  input  wire logic [i8dp_pkg::IDX_W-1:0]          element_index,
  input  wire logic signed [i8dp_pkg::VAL_W-1:0]   element_value,
  // result channel
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic signed [i8dp_pkg::SCORE_W-1:0]      score,
  output logic [i8dp_pkg::VNUM_W-1:0]              vector_number,
  // configuration channel
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic                                cfg_index,
  input  wire logic [i8dp_pkg::SCALE_W-1:0]        cfg_data
);

  i8dp_pkg::state_t state, state_next;

  logic [i8dp_pkg::SCALE_W-1:0]        scale;
  logic [i8dp_pkg::LEN_W-1:0]          vector_length;
  logic [i8dp_pkg::LEN_W-1:0]          eff_len;

  logic [i8dp_pkg::VAL_W-1:0]          query_mem [i8dp_pkg::QDEPTH];
  logic signed [i8dp_pkg::VAL_W-1:0]   q_rd;
  logic [i8dp_pkg::IDX_W-1:0]          idx_reg;
  logic signed [i8dp_pkg::VAL_W-1:0]   val_reg;

  logic signed [i8dp_pkg::ACC_W-1:0]   acc, acc_next;
  logic [i8dp_pkg::VNUM_W-1:0]         vector_counter;

  logic signed [i8dp_pkg::ACC_W-1:0]   mul_a;
  logic signed [i8dp_pkg::SCALE_W-1:0] mul_b;
  logic signed [i8dp_pkg::PROD_W-1:0]  mul_p, prod;
  logic                                mul_sel_scale;

  logic in_beat, cfg_beat, is_vec, in_range, is_last, out_free, emit;
  logic signed [i8dp_pkg::SCORE_W:0]   shifted;
  logic signed [i8dp_pkg::SCORE_W-1:0] score_sat;

  assign in_beat  = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign cfg_beat = cfg_valid && cfg_ready;
  assign is_vec   = (command == i8dp_pkg::CMD_VECTOR);

  // effective length, clamped to the supported maximum
  assign eff_len  = (vector_length > i8dp_pkg::MAX_LENGTH) ? i8dp_pkg::MAX_LENGTH
                                                           : vector_length;
  assign in_range = ({1'b0, element_index} < eff_len);
  assign is_last  = ({1'b0, idx_reg} == (eff_len - 9'd1));
  assign out_free = !out_valid || out_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      scale         <= i8dp_pkg::SCALE_RESET;
      vector_length <= i8dp_pkg::LENGTH_RESET;
    end else if (cfg_beat) begin
      case (cfg_index)
        i8dp_pkg::CFG_SCALE:  scale <= cfg_data;
        i8dp_pkg::CFG_LENGTH: vector_length <= cfg_data[i8dp_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // query memory: write on load beats, registered read on vector beats
  always_ff @(posedge clk) begin
    if (in_beat && !is_vec) begin
      query_mem[element_index] <= element_value;
    end
    if (in_beat && is_vec) begin
      q_rd <= query_mem[element_index];
    end
  end

  // captured item fields
  always_ff @(posedge clk) begin
    if (in_beat) begin
      idx_reg <= element_index;
      val_reg <= element_value;
    end
  end

  // shared multiplier: element product, then sum times scale
  always_comb begin
    if (mul_sel_scale) begin
      mul_a = acc;
      mul_b = scale;
    end else begin
      mul_a = {{(i8dp_pkg::ACC_W-i8dp_pkg::VAL_W){val_reg[i8dp_pkg::VAL_W-1]}}, val_reg};
      mul_b = {{(i8dp_pkg::SCALE_W-i8dp_pkg::VAL_W){q_rd[i8dp_pkg::VAL_W-1]}}, q_rd};
    end
  end
  assign mul_p = mul_a * mul_b;

  always_ff @(posedge clk) begin
    if (state == i8dp_pkg::ST_MUL || state == i8dp_pkg::ST_SCALE) begin
      prod <= mul_p;
    end
  end

  // accumulator, restarted at index zero, wraps at its width
  assign acc_next = ((idx_reg == '0) ? '0 : acc) + prod[i8dp_pkg::ACC_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (state == i8dp_pkg::ST_ACC) begin
      acc <= acc_next;
    end
  end

  // vector counter: cleared by a load, advanced on each score
  always_ff @(posedge clk) begin
    if (rst) begin
      vector_counter <= '0;
    end else if (in_beat && !is_vec) begin
      vector_counter <= '0;
    end else if (emit) begin
      vector_counter <= vector_counter + 16'd1;
    end
  end

  // floor shift by 16 and saturation to the score width
  assign shifted   = prod[i8dp_pkg::PROD_W-1:16];
  always_comb begin
    if (shifted[i8dp_pkg::SCORE_W] != shifted[i8dp_pkg::SCORE_W-1]) begin
      score_sat = shifted[i8dp_pkg::SCORE_W] ? i8dp_pkg::SCORE_MIN : i8dp_pkg::SCORE_MAX;
    end else begin
      score_sat = shifted[i8dp_pkg::SCORE_W-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      score         <= score_sat;
      vector_number <= vector_counter;
    end
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= i8dp_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      i8dp_pkg::ST_IDLE: begin
        if (in_beat && is_vec && in_range) state_next = i8dp_pkg::ST_MUL;
      end
      i8dp_pkg::ST_MUL:   state_next = i8dp_pkg::ST_ACC;
      i8dp_pkg::ST_ACC: begin
        state_next = is_last ? i8dp_pkg::ST_SCALE : i8dp_pkg::ST_IDLE;
      end
      i8dp_pkg::ST_SCALE: state_next = i8dp_pkg::ST_EMIT;
      i8dp_pkg::ST_EMIT: begin
        if (out_free) state_next = i8dp_pkg::ST_IDLE;
      end
      default: state_next = i8dp_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready      = 1'b0;
    mul_sel_scale = 1'b0;
    emit          = 1'b0;
    case (state)
      i8dp_pkg::ST_IDLE:  in_ready = 1'b1;
      i8dp_pkg::ST_MUL:   mul_sel_scale = 1'b0;
      i8dp_pkg::ST_ACC:   mul_sel_scale = 1'b0;
      i8dp_pkg::ST_SCALE: mul_sel_scale = 1'b1;
      i8dp_pkg::ST_EMIT:  emit = out_free;
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  // an in-range vector beat starts the multiply step
  a_vec_starts: assert property (@(posedge clk) disable iff (rst)
    (in_beat && is_vec && in_range) |=> (state == i8dp_pkg::ST_MUL))
    else $error("vector beat did not start multiply");

  // multiply is always followed by accumulate
  a_mul_acc: assert property (@(posedge clk) disable iff (rst)
    (state == i8dp_pkg::ST_MUL) |=> (state == i8dp_pkg::ST_ACC))
    else $error("multiply not followed by accumulate");

  // sum only moves in the accumulate step
  a_acc_hold: assert property (@(posedge clk) disable iff (rst)
    (state != i8dp_pkg::ST_ACC) |=> $stable(acc))
    else $error("accumulator changed outside accumulate");

  // a load beat clears the vector counter
  a_load_clears: assert property (@(posedge clk) disable iff (rst)
    (in_beat && !is_vec) |=> (vector_counter == '0))
    else $error("load did not clear vector counter");

  // an emitted score carries the counter value before it advances
  a_emit_number: assert property (@(posedge clk) disable iff (rst)
    emit |=> (out_valid && vector_number == $past(vector_counter)
              && vector_counter == $past(vector_counter) + 16'd1))
    else $error("emitted vector number mismatch");
`endif

endmodule
`default_nettype wire
